// ===== sv/chrot_pkg.sv =====
// Package for the choose-rotate-xor 256-bit permutation.
// Holds the state types, the per-step rotation amounts and the step helpers.
// No dependencies.
package chrot_pkg;

    localparam int unsigned WORD_W        = 64;
    localparam int unsigned WORD_CNT      = 4;
    localparam int unsigned STEP_CNT      = 8;
    localparam int unsigned ROUND_CNT_DEF = 2;

    typedef logic [WORD_W-1:0]                t_word;
    // word k of the state sits at bits [64k+63:64k]
    typedef logic [WORD_CNT-1:0][WORD_W-1:0]  t_state;

    localparam int unsigned ROT_AMT [STEP_CNT] = '{1, 2, 4, 8, 16, 32, 48, 56};

    // bitwise choose: take one_w where sel is set, else zero_w
    function automatic t_word choose(t_word sel, t_word one_w, t_word zero_w);
        return zero_w ^ (sel & (one_w ^ zero_w));
    endfunction

    // rotate left by a constant amount in 1..63
    function automatic t_word rotl(t_word x, int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

// ===== sv/chrot_round.sv =====
// One round of the permutation: eight dependent choose-rotate-xor steps.
// Pure combinational; depends on chrot_pkg.
module chrot_round (
    input  chrot_pkg::t_state i_state,
    output chrot_pkg::t_state o_state
);
    import chrot_pkg::*;

    // intermediate state after each step
    t_state w [STEP_CNT+1];

    assign w[0] = i_state;

    for (genvar s = 0; s < STEP_CNT; s++) begin : g_step
        localparam int unsigned TGT = s % WORD_CNT;
        localparam int unsigned SEL = (TGT + 1) % WORD_CNT;
        localparam int unsigned ONE = (TGT + 2) % WORD_CNT;
        localparam int unsigned ZRO = (TGT + 3) % WORD_CNT;

        t_word t_mix;
        assign t_mix = rotl(choose(w[s][SEL], w[s][ONE], w[s][ZRO]), ROT_AMT[s]);

        for (genvar k = 0; k < WORD_CNT; k++) begin : g_word
            if (k == TGT) begin : g_upd
                assign w[s+1][k] = w[s][k] ^ t_mix;
            end else begin : g_keep
                assign w[s+1][k] = w[s][k];
            end
        end
    end

    assign o_state = w[STEP_CNT];

endmodule

// ===== sv/choose_rotate_xor_permutation_256.sv =====
// Choose-rotate-xor 256-bit permutation, streaming top level.
// An accepted beat is held in the input register, then in the result register.
// Throughput: one beat per cycle while the master takes output; the two registers
// bracket a combinational chain of 8 * ROUND_COUNT choose-rotate-xor steps.
// Reset (synchronous, active low) clears both valid flags; data is not reset.
// Depends on chrot_pkg and chrot_round.
module choose_rotate_xor_permutation_256 #(
    parameter int unsigned ROUND_COUNT = chrot_pkg::ROUND_CNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [chrot_pkg::WORD_W*chrot_pkg::WORD_CNT-1:0] i_s_tdata,
        // word_a_in [63:0], word_b_in [127:64], word_c_in [191:128], word_d_in [255:192]
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [chrot_pkg::WORD_W*chrot_pkg::WORD_CNT-1:0] o_m_tdata
        // word_a_out [63:0], word_b_out [127:64], word_c_out [191:128], word_d_out [255:192]
);
    import chrot_pkg::*;

    // input stage
    logic   r_in_valid;
    t_state r_in_state;
    // result stage
    logic   r_out_valid;
    t_state r_out_state;

    logic   adv;        // result stage may load this cycle
    logic   in_load;    // input stage may load this cycle

    // The result register advances when empty or when its beat is taken.
    // The input register refills whenever its content moves on (or it is empty),
    // so a new beat is taken every cycle while the master keeps up.
    assign adv     = !r_out_valid || i_m_tready;
    assign in_load = !r_in_valid || adv;

    assign o_s_tready = in_load;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_state;

    // Round chain: state after each round
    t_state rnd [ROUND_COUNT+1];
    assign rnd[0] = r_in_state;

    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        chrot_round u_round (
            .i_state (rnd[r]),
            .o_state (rnd[r+1])
        );
    end

    // Valid flags: reset clears them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Data registers: hold while stalled, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_load && i_s_tvalid) begin
            r_in_state <= t_state'(i_s_tdata);
        end
        if (adv && r_in_valid) begin
            r_out_state <= rnd[ROUND_COUNT];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // the cycle after reset nothing is presented
    a_rst_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // a beat waiting in the input stage moves to the result stage when it advances
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && adv) |=> r_out_valid)
        else $error("input-stage beat lost on advance");

    // input side is only blocked when both stages are full and the master stalls
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without backpressure");

    // a new output beat only comes from a filled input stage
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_in_valid))
        else $error("output beat without source");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the 256-bit choose-rotate-xor permutation.
// Streams directed and random states through the block and compares each output beat
// with a local model of the rounds. Depends on chrot_pkg and the block under test.
module tb_top;

    import chrot_pkg::*;

    localparam int unsigned ROUNDS      = ROUND_CNT_DEF;
    localparam int unsigned STALL_LIMIT = 2000;   // cycles with no beat on either side
    localparam int unsigned SETTLE_CYC  = 8;      // settle time after the last results have drained
    localparam int unsigned REPORT_MAX  = 10;

    logic   clk      = 1'b0;
    logic   rst_n    = 1'b0;
    logic   s_tvalid = 1'b0;
    logic   s_tready;
    t_state s_tdata  = '0;       // word_a [63:0], word_b, word_c, word_d [255:192]
    logic   m_tvalid;
    logic   m_tready = 1'b0;
    t_state m_tdata;             // word_a [63:0], word_b, word_c, word_d [255:192]

    // Idling switches; each test sets them to suit what it exercises.
    bit tx_gap_on   = 1'b0;
    bit rx_stall_on = 1'b0;

    // Permuted states still owed by the block, oldest first.
    t_state permuted_q[$];
    t_state want_state;
    int unsigned mismatch_cnt = 0;
    int unsigned stall_cycles = 0;

    string word_name[WORD_CNT] = '{"word_a", "word_b", "word_c", "word_d"};

    choose_rotate_xor_permutation_256 #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the permutation
    // ------------------------------------------------------------------

    // Rotate left: take the upper half of the doubled word shifted by n.
    function automatic t_word rot_left(t_word x, int unsigned n);
        logic [2*WORD_W-1:0] twice;
        twice = {x, x} << n;
        return twice[2*WORD_W-1:WORD_W];
    endfunction

    // Run all rounds. Step s targets word s mod 4; the next word selects
    // between the two after it, and the pick is rotated into the target.
    function automatic t_state permute_state(t_state in_state);
        t_state w;
        t_word  picked;
        int unsigned tgt;
        w = in_state;
        for (int unsigned r = 0; r < ROUNDS; r++) begin
            for (int unsigned s = 0; s < STEP_CNT; s++) begin
                tgt    = s % WORD_CNT;
                picked = (w[(tgt + 1) % WORD_CNT] & w[(tgt + 2) % WORD_CNT])
                       | (~w[(tgt + 1) % WORD_CNT] & w[(tgt + 3) % WORD_CNT]);
                w[tgt] = w[tgt] ^ rot_left(picked, ROT_AMT[s]);
            end
        end
        return w;
    endfunction

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drive one state and hold it until the block takes the beat. When
    // idling is on, drop valid for a random gap first.
    task automatic send_state(input t_state st);
        int unsigned gap;
        gap = 0;
        if (tx_gap_on) begin
            while ($urandom_range(99) < 33)
                gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        permuted_q.push_back(permute_state(st));
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (permuted_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checker
    // ------------------------------------------------------------------

    // Stall the output about a third of the cycles when enabled.
    always @(posedge clk) begin
        m_tready <= rx_stall_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    // Compare every output beat, word by word, with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (permuted_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected output beat: %h", m_tdata);
            end else begin
                want_state = permuted_q.pop_front();
                for (int k = 0; k < WORD_CNT; k++) begin
                    if (m_tdata[k] !== want_state[k]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("%s mismatch: expected %h, got %h",
                                     word_name[k], want_state[k], m_tdata[k]);
                    end
                end
            end
        end
    end

    // End the run if no beat moves on either side for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edge patterns back to back: all zeros, all ones, one word full,
    // lowest and highest bit of each word, alternating bits, a mixed state.
    task automatic test_directed_patterns();
        t_state st;
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
        send_state('0);
        send_state('1);
        for (int k = 0; k < WORD_CNT; k++) begin
            st = '0;
            st[k] = '1;
            send_state(st);
            st = '0;
            st[k][0] = 1'b1;
            send_state(st);
            st = '0;
            st[k][WORD_W-1] = 1'b1;
            send_state(st);
        end
        send_state({WORD_CNT{64'h5555_5555_5555_5555}});
        send_state({WORD_CNT{64'hAAAA_AAAA_AAAA_AAAA}});
        send_state({64'hFEDC_BA98_7654_3210, 64'h0F0F_0F0F_F0F0_F0F0,
                    64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF});
    endtask

    // Random states with gaps on the input and stalls on the output.
    task automatic test_random_with_idling(input int unsigned count);
        t_state st;
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        for (int unsigned i = 0; i < count; i++) begin
            for (int k = 0; k < WORD_CNT; k++)
                st[k] = rand_word();
            send_state(st);
        end
    endtask

    // Full-rate stream with no idling at all.
    task automatic test_random_full_rate(input int unsigned count);
        t_state st;
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
            for (int k = 0; k < WORD_CNT; k++)
                st[k] = rand_word();
            send_state(st);
        end
    endtask

    // Sparse, dense and plain random words, mixed per word, so the choose sees
    // selectors that are mostly zero or mostly one.
    task automatic test_sparse_dense(input int unsigned count);
        t_state st;
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        for (int unsigned i = 0; i < count; i++) begin
            for (int k = 0; k < WORD_CNT; k++) begin
                case ($urandom_range(2))
                    0: st[k] = rand_word() & rand_word() & rand_word();
                    1: st[k] = rand_word() | rand_word() | rand_word();
                    default: st[k] = rand_word();
                endcase
            end
            send_state(st);
        end
    endtask

    // Bursts separated by a full drain of the pipeline.
    task automatic test_drain_between_bursts();
        for (int b = 0; b < 4; b++) begin
            test_random_with_idling($urandom_range(5, 15));
            wait_results_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_patterns();
        test_random_with_idling(150);
        test_drain_between_bursts();
        test_random_full_rate(100);
        test_sparse_dense(100);

        // Drop valid, let the last results drain, then settle.
        wait_results_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatch_cnt == 0 && permuted_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
